FILE: rtl/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants of the 1-Wire bus master: transaction payloads,
// configuration register set, register indexes and command kinds.
// ----------------------------------------------------------------------------
package owb_pkg;

  // Command kinds carried in the input transaction
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_RESET_LOW   = 3'd0;
  localparam logic [2:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL  = 3'd2;
  localparam logic [2:0] REG_WR1_LOW     = 3'd3;
  localparam logic [2:0] REG_WR0_LOW     = 3'd4;
  localparam logic [2:0] REG_RD_LOW      = 3'd5;
  localparam logic [2:0] REG_RD_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_SLOT        = 3'd7;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Reset values of the timing registers, in microseconds
  localparam logic [9:0] RST_RESET_LOW   = 10'd480;
  localparam logic [9:0] RST_PRES_SAMPLE = 10'd70;
  localparam logic [9:0] RST_RESET_TAIL  = 10'd410;
  localparam logic [6:0] RST_WR1_LOW     = 7'd6;
  localparam logic [6:0] RST_WR0_LOW     = 7'd60;
  localparam logic [6:0] RST_RD_LOW      = 7'd6;
  localparam logic [6:0] RST_RD_SAMPLE   = 7'd15;
  localparam logic [6:0] RST_SLOT        = 7'd70;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_sample_time;
    logic [9:0] reset_tail_time;
    logic [6:0] write_one_low_time;
    logic [6:0] write_zero_low_time;
    logic [6:0] read_low_time;
    logic [6:0] read_sample_time;
    logic [6:0] slot_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic       rejected;
  } out_item_t;

endpackage

FILE: rtl/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Standard-speed 1-Wire bus master: reset/presence, byte write, byte read.
// A transaction is held in the input register, its result in the result register.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset: asynchronous, timing registers return to their standard values,
// the master goes idle with the line released.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit #(
  parameter int unsigned TIME_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  owb_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output owb_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owb_pkg::APB_AW-1:0]  paddr,
  input  logic [owb_pkg::APB_DW-1:0]  pwdata,
  output logic [owb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  owb_pkg::cfg_t      cfg;
  owb_pkg::in_item_t  in_item_q;
  owb_pkg::out_item_t res, out_item_q;
  logic               in_vld_q, in_vld_d;
  logic               out_vld_q, out_vld_d;
  logic               out_free, proc, in_take;

  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign proc       = in_vld_q & out_free;
  assign in_stall_o = in_vld_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign in_vld_d   = in_take | (in_vld_q & ~proc);
  assign out_vld_d  = proc | (out_vld_q & out_stall_i);

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

  owb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owb_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (proc),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_item_q <= in_data_i;
    if (proc) out_item_q <= res;
  end

  // a held transaction in the input register waits unchanged for the result slot
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !proc |=> in_vld_q && $stable(in_item_q))
    else $error("pending transaction lost");

endmodule

FILE: rtl/owb_cfg_regs.sv
// ----------------------------------------------------------------------------
// owb_cfg_regs
// APB register file holding the bus timing durations.
// ----------------------------------------------------------------------------
module owb_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owb_pkg::APB_AW-1:0]  paddr,
  input  logic [owb_pkg::APB_DW-1:0]  pwdata,
  output logic [owb_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output owb_pkg::cfg_t               cfg_o
);

  owb_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        owb_pkg::REG_RESET_LOW:   cfg_d.reset_low_time       = pwdata[9:0];
        owb_pkg::REG_PRES_SAMPLE: cfg_d.presence_sample_time = pwdata[9:0];
        owb_pkg::REG_RESET_TAIL:  cfg_d.reset_tail_time      = pwdata[9:0];
        owb_pkg::REG_WR1_LOW:     cfg_d.write_one_low_time   = pwdata[6:0];
        owb_pkg::REG_WR0_LOW:     cfg_d.write_zero_low_time  = pwdata[6:0];
        owb_pkg::REG_RD_LOW:      cfg_d.read_low_time        = pwdata[6:0];
        owb_pkg::REG_RD_SAMPLE:   cfg_d.read_sample_time     = pwdata[6:0];
        owb_pkg::REG_SLOT:        cfg_d.slot_time            = pwdata[6:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      owb_pkg::REG_RESET_LOW:   prdata = 32'(cfg_q.reset_low_time);
      owb_pkg::REG_PRES_SAMPLE: prdata = 32'(cfg_q.presence_sample_time);
      owb_pkg::REG_RESET_TAIL:  prdata = 32'(cfg_q.reset_tail_time);
      owb_pkg::REG_WR1_LOW:     prdata = 32'(cfg_q.write_one_low_time);
      owb_pkg::REG_WR0_LOW:     prdata = 32'(cfg_q.write_zero_low_time);
      owb_pkg::REG_RD_LOW:      prdata = 32'(cfg_q.read_low_time);
      owb_pkg::REG_RD_SAMPLE:   prdata = 32'(cfg_q.read_sample_time);
      owb_pkg::REG_SLOT:        prdata = 32'(cfg_q.slot_time);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time       <= owb_pkg::RST_RESET_LOW;
      cfg_q.presence_sample_time <= owb_pkg::RST_PRES_SAMPLE;
      cfg_q.reset_tail_time      <= owb_pkg::RST_RESET_TAIL;
      cfg_q.write_one_low_time   <= owb_pkg::RST_WR1_LOW;
      cfg_q.write_zero_low_time  <= owb_pkg::RST_WR0_LOW;
      cfg_q.read_low_time        <= owb_pkg::RST_RD_LOW;
      cfg_q.read_sample_time     <= owb_pkg::RST_RD_SAMPLE;
      cfg_q.slot_time            <= owb_pkg::RST_SLOT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/owb_core.sv
// ----------------------------------------------------------------------------
// owb_core
// Bus master state: phase sequencer, microsecond counter, bit shifter and
// result flags. One transaction is applied per enabled cycle.
// ----------------------------------------------------------------------------
module owb_core #(
  parameter int unsigned TIME_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              proc_i,
  input  owb_pkg::in_item_t item_i,
  input  owb_pkg::cfg_t     cfg_i,
  output owb_pkg::out_item_t res_o
);

  localparam int unsigned CW = (TIME_BITS > 10) ? TIME_BITS : 10;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WAIT = 3'd2;
  localparam logic [2:0] PH_RST_TAIL = 3'd3;
  localparam logic [2:0] PH_SLOT     = 3'd4;

  typedef logic [TIME_BITS-1:0] cnt_t;
  typedef logic [CW-1:0]        cw_t;

  localparam cnt_t TMAX = '1;

  logic [2:0] phase_q, phase_d;
  logic [1:0] op_q, op_d;
  cnt_t       cnt_q, cnt_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       pres_q, pres_d;
  logic       drive_q, drive_d;
  logic [7:0] last_q, last_d;
  logic       done, rej;

  cnt_t       cnt_inc;
  logic [6:0] slot_len, rd_pt, rd_clip, low_len;

  // A 10-bit duration beyond the counter range is reached at saturation
  function automatic logic reached(input cnt_t cnt, input logic [9:0] dur);
    reached = (cw_t'(cnt) >= cw_t'(dur)) || (cnt == TMAX);
  endfunction

  assign cnt_inc  = (cnt_q == TMAX) ? cnt_q : cnt_q + cnt_t'(1);
  assign slot_len = (cfg_i.slot_time == 7'd0) ? 7'd1 : cfg_i.slot_time;
  assign rd_clip  = (cfg_i.read_sample_time > slot_len) ? slot_len : cfg_i.read_sample_time;
  assign rd_pt    = (rd_clip == 7'd0) ? 7'd1 : rd_clip;
  assign low_len  = (op_q == owb_pkg::KIND_WRITE) ?
                    (shift_q[0] ? cfg_i.write_one_low_time : cfg_i.write_zero_low_time) :
                    cfg_i.read_low_time;

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    drive_d = drive_q;
    last_d  = last_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (proc_i) begin
      if (item_i.kind == owb_pkg::KIND_TICK) begin
        if (phase_q != PH_IDLE) begin
          cnt_d = cnt_inc;
          unique case (phase_q)
            PH_RST_LOW: begin
              if (reached(cnt_inc, cfg_i.reset_low_time)) begin
                drive_d = 1'b0;
                cnt_d   = '0;
                phase_d = PH_RST_WAIT;
              end
            end
            PH_RST_WAIT: begin
              if (reached(cnt_inc, cfg_i.presence_sample_time)) begin
                pres_d  = ~item_i.line_level;
                cnt_d   = '0;
                phase_d = PH_RST_TAIL;
              end
            end
            PH_RST_TAIL: begin
              if (reached(cnt_inc, cfg_i.reset_tail_time)) begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
            default: begin
              if (cnt_inc >= cnt_t'(low_len)) drive_d = 1'b0;
              if (op_q == owb_pkg::KIND_READ && cnt_inc == cnt_t'(rd_pt)) begin
                shift_d = {item_i.line_level, shift_q[7:1]};
              end
              if (cnt_inc >= cnt_t'(slot_len)) begin
                if (op_q == owb_pkg::KIND_WRITE) shift_d = {1'b0, shift_q[7:1]};
                if (bit_q == 3'd7) begin
                  if (op_q == owb_pkg::KIND_READ) last_d = shift_d;
                  drive_d = 1'b0;
                  bit_d   = '0;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bit_d   = bit_q + 3'd1;
                  cnt_d   = '0;
                  drive_d = 1'b1;
                end
              end
            end
          endcase
        end
      end else if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        op_d    = item_i.kind;
        cnt_d   = '0;
        bit_d   = '0;
        drive_d = 1'b1;
        if (item_i.kind == owb_pkg::KIND_RESET) begin
          phase_d = PH_RST_LOW;
        end else begin
          shift_d = (item_i.kind == owb_pkg::KIND_WRITE) ? item_i.data : 8'd0;
          phase_d = PH_SLOT;
        end
      end
    end
  end

  always_comb begin
    res_o.drive_low  = drive_d;
    res_o.busy_res   = (phase_d != PH_IDLE);
    res_o.done_res   = done;
    res_o.presence   = pres_d;
    res_o.read_value = last_d;
    res_o.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= '0;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      drive_q <= 1'b0;
      last_q  <= '0;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      drive_q <= drive_d;
      last_q  <= last_d;
    end
  end

  // line is never held low once the master has gone idle
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> !drive_q)
    else $error("line driven low while idle");

  // bit position only advances inside byte slots
  a_bit_in_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_SLOT |-> bit_q == 3'd0)
    else $error("bit index set outside a slot");

  // reset tail follows release of the reset pulse
  a_tail_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RST_TAIL |-> !drive_q)
    else $error("line driven during reset tail");

  // a completion and a rejection never share a transaction
  a_done_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i |-> !(done && rej))
    else $error("done and rejected together");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 1-Wire bus master. A queue of transactions
// (ticks and commands) feeds a clocked driver, and a clocked monitor predicts
// the bus status for every accepted transaction and compares it field by
// field with what the master returns. Timing registers are written over APB
// between traffic phases and read back. The phases cover the reset values,
// all-zero timings, random short timings and the longest timings, where long
// operations are cut short by shortening their timing. Each random phase
// uses its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned TMAX        = 1023;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT
  } bus_phase_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid = 1'b0;
  owb_pkg::in_item_t          in_data = '0;
  logic                       out_stall = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [owb_pkg::APB_AW-1:0] paddr = '0;
  logic [owb_pkg::APB_DW-1:0] pwdata = '0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  owb_pkg::out_item_t         out_data_o;
  logic [owb_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  owb_pkg::in_item_t  txn_q[$];
  owb_pkg::out_item_t status_q[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_mix[4] = '{0, 65, 0, 19};
  int unsigned stall_mix[4] = '{0, 0, 65, 19};

  // Predicted master state and timing registers
  int unsigned cfgv[8];
  bus_phase_e  bph;
  logic [1:0]  op;
  int unsigned tcount;
  logic [2:0]  bitn;
  logic [7:0]  shreg;
  logic        pres;
  logic        drv;
  logic [7:0]  last_rd;

  one_wire_bus_master_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned at_least_one(int unsigned x);
    return (x < 1) ? 1 : x;
  endfunction

  function automatic int unsigned reg_mask(logic [2:0] idx);
    return (idx <= owb_pkg::REG_RESET_TAIL) ? 32'h3FF : 32'h7F;
  endfunction

  function automatic owb_pkg::out_item_t advance_bus_master(owb_pkg::in_item_t it);
    owb_pkg::out_item_t r;
    logic        fin;
    logic        rej;
    int unsigned slot_len;
    int unsigned low_len;
    int unsigned smp;
    fin = 1'b0;
    rej = 1'b0;
    if (it.kind == owb_pkg::KIND_TICK) begin
      if (bph != PH_IDLE) begin
        if (tcount < TMAX) tcount++;
        case (bph)
          PH_RST_LOW: begin
            if (tcount >= cfgv[owb_pkg::REG_RESET_LOW]) begin
              drv = 1'b0;
              tcount = 0;
              bph = PH_RST_WAIT;
            end
          end
          PH_RST_WAIT: begin
            if (tcount >= cfgv[owb_pkg::REG_PRES_SAMPLE]) begin
              pres = ~it.line_level;
              tcount = 0;
              bph = PH_RST_TAIL;
            end
          end
          PH_RST_TAIL: begin
            if (tcount >= cfgv[owb_pkg::REG_RESET_TAIL]) begin
              bph = PH_IDLE;
              fin = 1'b1;
            end
          end
          default: begin
            slot_len = at_least_one(cfgv[owb_pkg::REG_SLOT]);
            if (op == owb_pkg::KIND_WRITE)
              low_len = shreg[0] ? cfgv[owb_pkg::REG_WR1_LOW] : cfgv[owb_pkg::REG_WR0_LOW];
            else
              low_len = cfgv[owb_pkg::REG_RD_LOW];
            if (tcount >= low_len) drv = 1'b0;
            if (op == owb_pkg::KIND_READ) begin
              // sample point is pulled into the slot and onto its first tick at least
              smp = cfgv[owb_pkg::REG_RD_SAMPLE];
              if (smp > slot_len) smp = slot_len;
              smp = at_least_one(smp);
              if (tcount == smp) shreg = {it.line_level, shreg[7:1]};
            end
            if (tcount >= slot_len) begin
              if (op == owb_pkg::KIND_WRITE) shreg = shreg >> 1;
              if (bitn == 3'd7) begin
                if (op == owb_pkg::KIND_READ) last_rd = shreg;
                drv = 1'b0;
                bitn = '0;
                bph = PH_IDLE;
                fin = 1'b1;
              end else begin
                bitn++;
                tcount = 0;
                drv = 1'b1;
              end
            end
          end
        endcase
      end
    end else if (bph != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      op = it.kind;
      tcount = 0;
      bitn = '0;
      drv = 1'b1;
      if (it.kind == owb_pkg::KIND_RESET) begin
        bph = PH_RST_LOW;
      end else begin
        shreg = (it.kind == owb_pkg::KIND_WRITE) ? it.data : 8'h00;
        bph = PH_SLOT;
      end
    end
    r.drive_low  = drv;
    r.busy_res   = (bph != PH_IDLE);
    r.done_res   = fin;
    r.presence   = pres;
    r.read_value = last_rd;
    r.rejected   = rej;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  // Driver: next transaction goes out once the current one has been taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_o) begin
      if (txn_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= txn_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    owb_pkg::out_item_t e;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) status_q.push_back(advance_bus_master(in_data));
      if (out_valid_o && !out_stall) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("[%0t] unexpected result transaction", $time);
        end else begin
          e = status_q.pop_front();
          check_field("drive_low", e.drive_low, out_data_o.drive_low);
          check_field("busy_res", e.busy_res, out_data_o.busy_res);
          check_field("done_res", e.done_res, out_data_o.done_res);
          check_field("presence", e.presence, out_data_o.presence);
          check_field("read_value", e.read_value, out_data_o.read_value);
          check_field("rejected", e.rejected, out_data_o.rejected);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** one_wire_bus_master_unit: FAILED **");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [owb_pkg::APB_DW-1:0] wdat,
                            output logic [owb_pkg::APB_DW-1:0] rdat);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdat;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdat = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a timing register (stray upper bits optional), then read it back
  task automatic set_timing(input logic [2:0] idx, input int unsigned val, input bit junk);
    logic [owb_pkg::APB_DW-1:0] wdat;
    logic [owb_pkg::APB_DW-1:0] rdat;
    wdat = val;
    if (junk) wdat = wdat | ($urandom() & ~reg_mask(idx));
    apb_access(1'b1, idx, wdat, rdat);
    cfgv[idx] = wdat & reg_mask(idx);
    apb_access(1'b0, idx, '0, rdat);
    check_field("register readback", cfgv[idx], rdat);
  endtask

  task automatic push_txn(input logic [1:0] k, input logic [7:0] d, input logic lvl);
    owb_pkg::in_item_t it;
    it.kind       = k;
    it.data       = d;
    it.line_level = lvl;
    txn_q.push_back(it);
  endtask

  task automatic push_tick(input logic lvl);
    push_txn(owb_pkg::KIND_TICK, 8'($urandom_range(0, 255)), lvl);
  endtask

  // One command and enough ticks to finish it; unless clean, the tick run may
  // be cut short or carry a command that arrives while busy
  task automatic plan_op(input logic [1:0] k, input bit clean);
    int unsigned need;
    int          intr;
    need = (k == owb_pkg::KIND_RESET) ?
           at_least_one(cfgv[owb_pkg::REG_RESET_LOW]) +
           at_least_one(cfgv[owb_pkg::REG_PRES_SAMPLE]) +
           at_least_one(cfgv[owb_pkg::REG_RESET_TAIL]) :
           8 * at_least_one(cfgv[owb_pkg::REG_SLOT]);
    intr = -1;
    if (!clean && $urandom_range(0, 9) == 0) need = $urandom_range(0, need);
    if (!clean && $urandom_range(0, 4) == 0) intr = $urandom_range(0, need);
    push_txn(k, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int i = 0; i < need; i++) begin
      if (i == intr)
        push_txn(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      push_tick(1'($urandom_range(0, 1)));
    end
    if (!clean) repeat ($urandom_range(0, 2)) push_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    while (txn_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned target;
    logic [owb_pkg::APB_DW-1:0] rdat;
    cfgv = '{owb_pkg::RST_RESET_LOW, owb_pkg::RST_PRES_SAMPLE, owb_pkg::RST_RESET_TAIL,
             owb_pkg::RST_WR1_LOW, owb_pkg::RST_WR0_LOW, owb_pkg::RST_RD_LOW,
             owb_pkg::RST_RD_SAMPLE, owb_pkg::RST_SLOT};
    bph = PH_IDLE;
    op = '0;
    tcount = 0;
    bitn = '0;
    shreg = '0;
    pres = 1'b0;
    drv = 1'b0;
    last_rd = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values read back, then the first part of a reset pulse at standard timing
    for (int i = 0; i < 8; i++) begin
      apb_access(1'b0, 3'(i), '0, rdat);
      check_field("register reset value", cfgv[i], rdat);
    end
    push_txn(owb_pkg::KIND_RESET, 8'h00, 1'b1);
    repeat (40) push_tick(1'b1);
    push_txn(owb_pkg::KIND_READ, 8'h00, 1'b0);     // busy, rejected
    drain();

    // all-zero timings: every phase collapses to a single tick
    for (int i = 0; i < 8; i++) set_timing(3'(i), 0, 1'b0);
    repeat (2) push_tick(1'b1);            // pending pulse released, no device
    push_tick(1'b1);                       // tail ends
    push_tick(1'b1);                       // idle tick does nothing
    push_txn(owb_pkg::KIND_RESET, 8'hFF, 1'b0);
    push_txn(owb_pkg::KIND_WRITE, 8'h5A, 1'b1);     // busy, rejected
    push_tick(1'b1);
    push_tick(1'b0);                       // device present
    push_tick(1'b1);
    push_txn(owb_pkg::KIND_RESET, 8'h00, 1'b1);
    repeat (2) push_tick(1'b0);
    push_tick(1'b1);                       // tail ends; the low tick before it sampled a device present
    push_tick(1'b0);
    push_txn(owb_pkg::KIND_WRITE, 8'hFF, 1'b0);
    for (int i = 0; i < 8; i++) push_tick(i[0]);
    push_txn(owb_pkg::KIND_WRITE, 8'h00, 1'b1);
    for (int i = 0; i < 8; i++) push_tick(i[1]);
    push_txn(owb_pkg::KIND_READ, 8'hFF, 1'b1);
    push_tick(1'b1);
    push_txn(owb_pkg::KIND_RESET, 8'h00, 1'b0);     // busy, rejected
    for (int i = 1; i < 8; i++) push_tick(i < 4);
    drain();

    // random short timings, one idling pattern per phase
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 8; i++)
        set_timing(3'(i), (i == owb_pkg::REG_SLOT) ? $urandom_range(0, 10) :
                   $urandom_range(0, 12), 1'b1);
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      target = txn_q.size() + 100;
      while (txn_q.size() < target) plan_op(2'($urandom_range(1, 3)), 1'b0);
      drain();
    end

    // enough ticks to finish any operation left open by the random traffic
    repeat (100) push_tick(1'($urandom_range(0, 1)));
    drain();

    // longest timings: a reset pulse shortened once it is under way, then the
    // first slot of a byte write
    for (int i = 0; i < 8; i++) set_timing(3'(i), reg_mask(3'(i)), 1'b0);
    push_txn(owb_pkg::KIND_RESET, 8'h00, 1'b0);
    repeat (60) push_tick(1'b0);
    drain();
    for (int i = 0; i < 3; i++) set_timing(3'(i), 1, 1'b0);
    repeat (3) push_tick(1'b0);            // release, device present, end of pulse
    push_txn(owb_pkg::KIND_WRITE, 8'hA5, 1'b1);
    repeat (140) push_tick(1'b1);
    drain();

    repeat (10) @(posedge clk_i);
    if (status_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("** one_wire_bus_master_unit: PASSED **");
    end else begin
      $display("** one_wire_bus_master_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/owb_pkg.sv
rtl/owb_cfg_regs.sv
rtl/owb_core.sv
rtl/one_wire_bus_master_unit.sv
tb/tb.sv
